// File: rtl/ipfk_pkg.sv
// shared types, codes and constants of the ip flow key classifier
package ipfk_pkg;

   localparam int CNT_W   = 64;
   localparam int NUM_CNT = 8;
   localparam int QDEPTH  = 4;
   localparam int QAW     = $clog2(QDEPTH);
   localparam int QCW     = $clog2(QDEPTH + 1);

   localparam logic KIND_PKT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [2:0] CNT_SEEN      = 3'd0;
   localparam logic [2:0] CNT_NOT_IP    = 3'd1;
   localparam logic [2:0] CNT_V4        = 3'd2;
   localparam logic [2:0] CNT_V6        = 3'd3;
   localparam logic [2:0] CNT_FRAG_OPTS = 3'd4;
   localparam logic [2:0] CNT_NOT_L4    = 3'd5;
   localparam logic [2:0] CNT_SHORT     = 3'd6;
   localparam logic [2:0] CNT_ELIGIBLE  = 3'd7;

   localparam logic [3:0]  VER_4      = 4'd4;
   localparam logic [3:0]  VER_6      = 4'd6;
   localparam logic [3:0]  IHL_BASE   = 4'd5;
   localparam logic [6:0]  V4_HDR_LEN = 7'd20;
   localparam logic [6:0]  V6_HDR_LEN = 7'd40;
   localparam logic [6:0]  PORT_BYTES = 7'd4;
   localparam logic [5:0]  POS_MAX    = 6'd63;
   localparam logic [15:0] FRAG_MF    = 16'h2000;
   localparam logic [15:0] FRAG_OFS   = 16'h1fff;

   localparam logic [7:0] PROTO_TCP   = 8'd6;
   localparam logic [7:0] PROTO_UDP   = 8'd17;
   localparam logic [7:0] NH_HOPOPT   = 8'd0;
   localparam logic [7:0] NH_ROUTING  = 8'd43;
   localparam logic [7:0] NH_FRAGMENT = 8'd44;
   localparam logic [7:0] NH_ESP      = 8'd50;
   localparam logic [7:0] NH_AH       = 8'd51;
   localparam logic [7:0] NH_DSTOPTS  = 8'd60;
   localparam logic [7:0] NH_MOBILITY = 8'd135;

   typedef enum logic [2:0] {
      VD_OK,
      VD_NOT_IP,
      VD_SHORT,
      VD_FRAG_OPTS,
      VD_NOT_L4
   } ipfk_verdict_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  packet_byte;
      logic        end_of_packet;
      logic [15:0] ingress_if;
      logic [2:0]  counter_select;
   } ipfk_req_type;

   typedef struct packed {
      logic             result_kind;
      ipfk_verdict_type verdict;
      logic             is_ipv6;
      logic [7:0]       protocol;
      logic [7:0]       tos;
      logic [15:0]      total_length;
      logic [15:0]      src_port;
      logic [15:0]      dst_port;
      logic [15:0]      ingress_port;
      logic [63:0]      data_word;
      logic [1:0]       word_index;
      logic             last_in_run;
   } ipfk_rsp_type;

   typedef struct packed {
      logic             result_kind;
      ipfk_verdict_type verdict;
      logic             is_ipv6;
      logic [7:0]       protocol;
      logic [7:0]       tos;
      logic [15:0]      total_length;
      logic [15:0]      src_port;
      logic [15:0]      dst_port;
      logic [15:0]      ingress_port;
      logic [3:0][63:0] words;
   } ipfk_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ipfk_qstat_type;

endpackage

// File: rtl/ipfk_front.sv
// front end: header capture, verdict, statistics counters and queue push
module ipfk_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ipfk_pkg::ipfk_req_type  req_data,
   input  ipfk_pkg::ipfk_qstat_type qstat,
   output logic                    push,
   output ipfk_pkg::ipfk_entry_type push_entry
);
   import ipfk_pkg::*;

   logic [5:0]        pos_ff, pos_in;
   logic [7:0]        b0_ff, b0_in;
   logic [7:0]        tos_ff, tos_in;
   logic [15:0]       tlen_ff, tlen_in;
   logic [15:0]       frag_ff, frag_in;
   logic [7:0]        proto_ff, proto_in;
   logic [1:0][63:0]  src_ff, src_in;
   logic [1:0][63:0]  dst_ff, dst_in;
   logic [31:0]       ports_ff, ports_in;
   logic [15:0]       ifidx_ff, ifidx_in;
   logic [NUM_CNT-1:0][CNT_W-1:0] cnt_ff, cnt_in;

   logic              accept;
   logic              take_byte;
   logic              pkt_done;
   logic [3:0]        ver_q;
   logic [3:0]        ver_n;
   logic [2:0]        lane;
   logic [7:0]        pb;
   logic [6:0]        len;
   logic              is_l4;
   logic [NUM_CNT-1:0] bump;
   ipfk_verdict_type  verdict;

   function automatic logic is_ext_header(input logic [7:0] nh);
      return nh == NH_HOPOPT || nh == NH_ROUTING || nh == NH_FRAGMENT ||
             nh == NH_ESP || nh == NH_AH || nh == NH_DSTOPTS || nh == NH_MOBILITY;
   endfunction

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;
   assign take_byte = accept && req_data.kind == KIND_PKT;
   assign pkt_done  = take_byte && req_data.end_of_packet;
   assign push      = accept && (req_data.kind == KIND_READ || req_data.end_of_packet);
   assign pb        = req_data.packet_byte;
   assign ver_q     = b0_ff[7:4];

   // header capture
   always_comb begin
      pos_in   = pos_ff;
      b0_in    = b0_ff;
      tos_in   = tos_ff;
      tlen_in  = tlen_ff;
      frag_in  = frag_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      ports_in = ports_ff;
      ifidx_in = ifidx_ff;
      lane     = (ver_q == VER_6) ? ~pos_ff[2:0] : {1'b0, ~pos_ff[1:0]};
      if (take_byte) begin
         if (pos_ff == '0) begin
            b0_in    = pb;
            tos_in   = '0;
            tlen_in  = '0;
            frag_in  = '0;
            proto_in = '0;
            src_in   = '0;
            dst_in   = '0;
            ports_in = '0;
            ifidx_in = req_data.ingress_if;
         end else if (ver_q == VER_4) begin
            case (pos_ff)
               6'd1: tos_in = pb;
               6'd2: tlen_in[15:8] = pb;
               6'd3: tlen_in[7:0] = pb;
               6'd6: frag_in[15:8] = pb;
               6'd7: frag_in[7:0] = pb;
               6'd9: proto_in = pb;
               default: ;
            endcase
            if (pos_ff[5:2] == 4'd3) src_in[1][{lane, 3'b000} +: 8] = pb;
            if (pos_ff[5:2] == 4'd4) dst_in[1][{lane, 3'b000} +: 8] = pb;
            if (pos_ff[5:2] == 4'd5) ports_in[{~pos_ff[1:0], 3'b000} +: 8] = pb;
         end else if (ver_q == VER_6) begin
            if (pos_ff == 6'd6) proto_in = pb;
            if (pos_ff[5:3] == 3'd1) src_in[0][{lane, 3'b000} +: 8] = pb;
            if (pos_ff[5:3] == 3'd2) src_in[1][{lane, 3'b000} +: 8] = pb;
            if (pos_ff[5:3] == 3'd3) dst_in[0][{lane, 3'b000} +: 8] = pb;
            if (pos_ff[5:3] == 3'd4) dst_in[1][{lane, 3'b000} +: 8] = pb;
            if (pos_ff[5:2] == 4'd10) ports_in[{~pos_ff[1:0], 3'b000} +: 8] = pb;
         end
         if (req_data.end_of_packet) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   // verdict on the captured header
   assign ver_n = b0_in[7:4];
   assign len   = {1'b0, pos_ff} + 7'd1;
   assign is_l4 = proto_in == PROTO_TCP || proto_in == PROTO_UDP;

   always_comb begin
      bump           = '0;
      verdict        = VD_OK;
      bump[CNT_SEEN] = 1'b1;
      if (ver_n == VER_4) begin
         if (len < V4_HDR_LEN) begin
            verdict = VD_SHORT;
         end else begin
            bump[CNT_V4] = 1'b1;
            if (b0_in[3:0] != IHL_BASE || (frag_in & (FRAG_MF | FRAG_OFS)) != '0) begin
               verdict = VD_FRAG_OPTS;
            end else if (!is_l4) begin
               verdict = VD_NOT_L4;
            end else if (len < V4_HDR_LEN + PORT_BYTES) begin
               verdict = VD_SHORT;
            end
         end
      end else if (ver_n == VER_6) begin
         if (len < V6_HDR_LEN) begin
            verdict = VD_SHORT;
         end else begin
            bump[CNT_V6] = 1'b1;
            if (!is_l4) begin
               verdict = is_ext_header(proto_in) ? VD_FRAG_OPTS : VD_NOT_L4;
            end else if (len < V6_HDR_LEN + PORT_BYTES) begin
               verdict = VD_SHORT;
            end
         end
      end else begin
         verdict = VD_NOT_IP;
      end
      case (verdict)
         VD_OK:        bump[CNT_ELIGIBLE]  = 1'b1;
         VD_NOT_IP:    bump[CNT_NOT_IP]    = 1'b1;
         VD_SHORT:     bump[CNT_SHORT]     = 1'b1;
         VD_FRAG_OPTS: bump[CNT_FRAG_OPTS] = 1'b1;
         VD_NOT_L4:    bump[CNT_NOT_L4]    = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < NUM_CNT; i++) begin
         if (pkt_done && bump[i]) cnt_in[i] = cnt_ff[i] + CNT_W'(1);
      end
   end

   // queue word
   always_comb begin
      push_entry = '0;
      if (req_data.kind == KIND_READ) begin
         push_entry.result_kind = KIND_READ;
         push_entry.words[0]    = 64'(cnt_ff[req_data.counter_select]);
      end else begin
         push_entry.result_kind  = KIND_PKT;
         push_entry.verdict      = verdict;
         push_entry.is_ipv6      = ver_n == VER_6;
         push_entry.ingress_port = ifidx_in;
         if (verdict == VD_OK) begin
            push_entry.protocol     = proto_in;
            push_entry.tos          = tos_in;
            push_entry.total_length = tlen_in;
            push_entry.src_port     = ports_in[31:16];
            push_entry.dst_port     = ports_in[15:0];
            push_entry.words        = {dst_in[1], dst_in[0], src_in[1], src_in[0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff    <= b0_in;
      tos_ff   <= tos_in;
      tlen_ff  <= tlen_in;
      frag_ff  <= frag_in;
      proto_ff <= proto_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      ports_ff <= ports_in;
      ifidx_ff <= ifidx_in;
   end

endmodule

// File: rtl/ipfk_queue.sv
// short queue of result descriptors between front and back
module ipfk_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ipfk_pkg::ipfk_entry_type push_entry,
   input  logic                     pop,
   output ipfk_pkg::ipfk_entry_type head,
   output ipfk_pkg::ipfk_qstat_type qstat
);
   import ipfk_pkg::*;

   ipfk_entry_type      mem_ff [QDEPTH];
   logic [QAW-1:0]      wr_ff, wr_in;
   logic [QAW-1:0]      rd_ff, rd_in;
   logic [QCW-1:0]      cnt_ff, cnt_in;

   assign head        = mem_ff[rd_ff];
   assign qstat.full  = cnt_ff == QCW'(QDEPTH);
   assign qstat.empty = cnt_ff == '0;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == QAW'(QDEPTH - 1)) ? '0 : wr_ff + QAW'(1);
      if (pop)  rd_in = (rd_ff == QAW'(QDEPTH - 1)) ? '0 : rd_ff + QAW'(1);
      if (push && !pop) cnt_in = cnt_ff + QCW'(1);
      if (pop && !push) cnt_in = cnt_ff - QCW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push) else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCW'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: rtl/ipfk_back.sv
// back end: splits descriptors into result words behind an output register
module ipfk_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ipfk_pkg::ipfk_entry_type head,
   input  ipfk_pkg::ipfk_qstat_type qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ipfk_pkg::ipfk_rsp_type   rsp_data
);
   import ipfk_pkg::*;

   logic [1:0]   beat_ff, beat_in;
   logic         rsp_valid_ff, rsp_valid_in;
   ipfk_rsp_type rsp_data_ff, rsp_data_in;
   logic         load;
   logic         four_beat;
   logic         last;

   assign four_beat = head.result_kind == KIND_PKT && head.verdict == VD_OK;
   assign load      = !qstat.empty && (!rsp_valid_ff || !rsp_stall);
   assign last      = !four_beat || beat_ff == 2'd3;
   assign pop       = load && last;

   always_comb begin
      beat_in      = beat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         beat_in                  = last ? 2'd0 : beat_ff + 2'd1;
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_kind  = head.result_kind;
         rsp_data_in.verdict      = head.verdict;
         rsp_data_in.is_ipv6      = head.is_ipv6;
         rsp_data_in.protocol     = head.protocol;
         rsp_data_in.tos          = head.tos;
         rsp_data_in.total_length = head.total_length;
         rsp_data_in.src_port     = head.src_port;
         rsp_data_in.dst_port     = head.dst_port;
         rsp_data_in.ingress_port = head.ingress_port;
         rsp_data_in.data_word    = head.words[beat_ff];
         rsp_data_in.word_index   = beat_ff;
         rsp_data_in.last_in_run  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_mid_run_head: assert property (@(posedge clock) disable iff (reset)
      beat_ff != 2'd0 |-> !qstat.empty && four_beat)
      else $error("word run without an eligible descriptor");
   a_inner_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last_in_run |->
      rsp_data_ff.result_kind == KIND_PKT && rsp_data_ff.verdict == VD_OK)
      else $error("non-final word outside an eligible run");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && beat_ff == 2'd0)
      else $error("output not idle after reset");
`endif

endmodule

// File: rtl/ip_flow_key_classifier.sv
// ip flow key classifier top level: front end, descriptor queue and back end
//
//  channel | dir | handshake            | word
//  req     | in  | req_valid/req_stall  | ipfk_req_type: packet byte or counter read
//  rsp     | out | rsp_valid/rsp_stall  | ipfk_rsp_type: verdict, key word or counter
//
// one request word per cycle unless stalled; an eligible packet gives four words
// first response word passes through the descriptor queue, then the output register
// req_stall follows the four deep descriptor queue being full
// synchronous reset clears byte position, counters, queue and output register
module ip_flow_key_classifier (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ipfk_pkg::ipfk_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ipfk_pkg::ipfk_rsp_type rsp_data
);
   import ipfk_pkg::*;

   logic           push;
   logic           pop;
   ipfk_entry_type push_entry;
   ipfk_entry_type head;
   ipfk_qstat_type qstat;

   ipfk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   ipfk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   ipfk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
